// ----- rtl/wmsf_pkg.sv -----
// ----------------------------------------------------------------------------
// wmsf_pkg: shared types and constants of the mean-shift window filter
// Holds the command/status structs, the state enum, the config register
// indexes and the Gaussian kernel table.
// ----------------------------------------------------------------------------
package wmsf_pkg;

  localparam int unsigned RADIUS_DEF      = 2;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  localparam logic [7:0] TOL_RST   = 8'd3;
  localparam logic [7:0] LIMIT_RST = 8'd32;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 1'd1;

  localparam logic [4:0] KTAB_LEN = 5'd24;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_RD,
    ST_INIT_EST,
    ST_ITER,
    ST_RD,
    ST_DIST,
    ST_DIV,
    ST_KERN,
    ST_ACC,
    ST_MEAN,
    ST_MDIV,
    ST_UPD,
    ST_EMIT
  } wmsf_state_e;

  typedef struct packed {
    logic load;
    logic init_rd;
    logic init_est;
    logic iter_start;
    logic rd;
    logic dist_start;
    logic kern;
    logic acc;
    logic mean_start;
    logic update;
    logic emit;
  } wmsf_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_idx;
    logic ws_zero;
    logic stop;
    logic out_free;
  } wmsf_status_t;

  // round(2^24 * exp(-k*k/32)), step of 1/4 grey level
  function automatic logic [24:0] ktab(input logic [4:0] k);
    logic [24:0] v;
    unique case (k)
      5'd0:    v = 25'd16777216;
      5'd1:    v = 25'd16261035;
      5'd2:    v = 25'd14805841;
      5'd3:    v = 25'd12664107;
      5'd4:    v = 25'd10175896;
      5'd5:    v = 25'd7681170;
      5'd6:    v = 25'd5446765;
      5'd7:    v = 25'd3628327;
      5'd8:    v = 25'd2270549;
      5'd9:    v = 25'd1334788;
      5'd10:   v = 25'd737139;
      5'd11:   v = 25'd382423;
      5'd12:   v = 25'd186378;
      5'd13:   v = 25'd85330;
      5'd14:   v = 25'd36700;
      5'd15:   v = 25'd14828;
      5'd16:   v = 25'd5628;
      5'd17:   v = 25'd2007;
      5'd18:   v = 25'd672;
      5'd19:   v = 25'd212;
      5'd20:   v = 25'd63;
      5'd21:   v = 25'd17;
      5'd22:   v = 25'd5;
      5'd23:   v = 25'd1;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/wmsf_px_if.sv -----
// ----------------------------------------------------------------------------
// wmsf_px_if: pixel input channel
// Valid/ready channel carrying one window pixel and its last mark.
// ----------------------------------------------------------------------------
interface wmsf_px_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       last_pixel;

  modport source (output valid, output pixel, output last_pixel, input ready);
  modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

// ----- rtl/wmsf_res_if.sv -----
// ----------------------------------------------------------------------------
// wmsf_res_if: filter result channel
// Valid/ready channel carrying one filtered value per window.
// ----------------------------------------------------------------------------
interface wmsf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered_value;
  logic       limit_hit;
  logic [7:0] iterations_used;

  modport source (output valid, output filtered_value, output limit_hit,
                  output iterations_used, input ready);
  modport sink   (input valid, input filtered_value, input limit_hit,
                  input iterations_used, output ready);
endinterface

// ----- rtl/wmsf_div.sv -----
// ----------------------------------------------------------------------------
// wmsf_div: sequential restoring divider
// 16-bit quotient, one bit per cycle; dividend must be < divisor * 2^16.
// ----------------------------------------------------------------------------
module wmsf_div #(
  parameter int unsigned VW = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [VW+15:0]  dividend_i,
  input  logic [VW-1:0]   divisor_i,
  output logic            done_o,
  output logic [15:0]     quot_o
);

  logic [VW-1:0] rem_q;
  logic [15:0]   quo_q;
  logic [VW-1:0] dvs_q;
  logic [3:0]    cnt_q;
  logic          busy_q, done_q;
  logic [VW:0]   trial, dvs_ext;
  logic          ge;

  assign trial   = {rem_q, quo_q[15]};
  assign dvs_ext = {1'b0, dvs_q};
  assign ge      = (trial >= dvs_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[VW+15:16];
      quo_q <= dividend_i[15:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? VW'(trial - dvs_ext) : trial[VW-1:0];
      quo_q <= {quo_q[14:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- rtl/wmsf_ctrl.sv -----
// ----------------------------------------------------------------------------
// wmsf_ctrl: sequencer of the mean-shift filter
// Walks load, per-pixel weighting, mean division and emit.
// ----------------------------------------------------------------------------
module wmsf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_last_i,
  output logic                  in_ready_o,
  input  wmsf_pkg::wmsf_status_t st_i,
  output wmsf_pkg::wmsf_cmd_t    cmd_o
);

  wmsf_pkg::wmsf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= wmsf_pkg::ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wmsf_pkg::ST_IDLE:     if (in_valid_i && in_last_i) state_d = wmsf_pkg::ST_INIT_RD;
      wmsf_pkg::ST_INIT_RD:  state_d = wmsf_pkg::ST_INIT_EST;
      wmsf_pkg::ST_INIT_EST: state_d = wmsf_pkg::ST_ITER;
      wmsf_pkg::ST_ITER:     state_d = wmsf_pkg::ST_RD;
      wmsf_pkg::ST_RD:       state_d = wmsf_pkg::ST_DIST;
      wmsf_pkg::ST_DIST:     state_d = wmsf_pkg::ST_DIV;
      wmsf_pkg::ST_DIV:      if (st_i.div_done) state_d = wmsf_pkg::ST_KERN;
      wmsf_pkg::ST_KERN:     state_d = wmsf_pkg::ST_ACC;
      wmsf_pkg::ST_ACC:      state_d = st_i.last_idx ? wmsf_pkg::ST_MEAN : wmsf_pkg::ST_RD;
      wmsf_pkg::ST_MEAN:     state_d = st_i.ws_zero ? wmsf_pkg::ST_EMIT : wmsf_pkg::ST_MDIV;
      wmsf_pkg::ST_MDIV:     if (st_i.div_done) state_d = wmsf_pkg::ST_UPD;
      wmsf_pkg::ST_UPD:      state_d = st_i.stop ? wmsf_pkg::ST_EMIT : wmsf_pkg::ST_ITER;
      wmsf_pkg::ST_EMIT:     if (st_i.out_free) state_d = wmsf_pkg::ST_IDLE;
      default:               state_d = wmsf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      wmsf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      wmsf_pkg::ST_INIT_RD:  cmd_o.init_rd    = 1'b1;
      wmsf_pkg::ST_INIT_EST: cmd_o.init_est   = 1'b1;
      wmsf_pkg::ST_ITER:     cmd_o.iter_start = 1'b1;
      wmsf_pkg::ST_RD:       cmd_o.rd         = 1'b1;
      wmsf_pkg::ST_DIST:     cmd_o.dist_start = 1'b1;
      wmsf_pkg::ST_KERN:     cmd_o.kern       = 1'b1;
      wmsf_pkg::ST_ACC:      cmd_o.acc        = 1'b1;
      wmsf_pkg::ST_MEAN:     cmd_o.mean_start = !st_i.ws_zero;
      wmsf_pkg::ST_UPD:      cmd_o.update     = 1'b1;
      wmsf_pkg::ST_EMIT:     cmd_o.emit       = st_i.out_free;
      default: ;
    endcase
  end

  // divider only finishes while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_i.div_done |-> (state_q == wmsf_pkg::ST_DIV || state_q == wmsf_pkg::ST_MDIV))
    else $error("divider done outside a wait state");

  // a search ends in emit, and leaves to idle only once the output register is free
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> state_q == wmsf_pkg::ST_IDLE)
    else $error("emit did not return to idle");

  // no pixel is taken while a search runs
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != wmsf_pkg::ST_IDLE) |-> !cmd_o.load)
    else $error("load while searching");

endmodule

// ----- rtl/wmsf_dp.sv -----
// ----------------------------------------------------------------------------
// wmsf_dp: datapath of the mean-shift filter
// Window memory, distance/kernel weighting, accumulators, estimate and
// output register; one shared divider.
// ----------------------------------------------------------------------------
module wmsf_dp #(
  parameter int unsigned RADIUS      = wmsf_pkg::RADIUS_DEF,
  parameter int unsigned WEIGHT_BITS = wmsf_pkg::WEIGHT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wmsf_pkg::wmsf_cmd_t    cmd_i,
  output wmsf_pkg::wmsf_status_t st_o,
  input  logic [7:0]             pixel_i,
  input  logic                   last_i,
  input  logic [7:0]             tol_i,
  input  logic [7:0]             limit_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [7:0]             filtered_value_o,
  output logic                   limit_hit_o,
  output logic [7:0]             iterations_used_o
);

  localparam int unsigned SIDE   = 2 * RADIUS + 1;
  localparam int unsigned NPIX   = SIDE * SIDE;
  localparam int unsigned CENTRE = 2 * RADIUS * RADIUS + 2 * RADIUS;
  localparam int unsigned AW     = $clog2(NPIX);
  localparam int unsigned DW     = $clog2(CENTRE + 1);
  localparam int unsigned WW     = WEIGHT_BITS + 1;   // weight incl. 1.0
  localparam int unsigned SW     = WEIGHT_BITS + 8;   // weight sum
  localparam int unsigned TW     = WEIGHT_BITS + 16;  // weighted total
  localparam logic [AW-1:0] CENTRE_A = AW'(CENTRE);
  localparam logic [AW-1:0] LAST_A   = AW'(NPIX - 1);

  logic [7:0]    mem [NPIX];
  logic [7:0]    rdata_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] load_cnt_q, idx_q;
  logic [15:0]   est_q;
  logic [SW-1:0] ws_q;
  logic [TW-1:0] wt_q;
  logic [7:0]    iter_q;
  logic [7:0]    pix_q;
  logic [WW-1:0] w_q;
  logic          hit_q;
  logic          out_valid_q;
  logic [7:0]    fv_q, iu_q;
  logic          lh_q;

  // window memory
  assign rd_addr = cmd_i.init_rd ? CENTRE_A : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) mem[load_cnt_q] <= pixel_i;
    if (cmd_i.init_rd || cmd_i.rd) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) load_cnt_q <= '0;
    else if (cmd_i.load) begin
      if (last_i || load_cnt_q == LAST_A) load_cnt_q <= '0;
      else                                load_cnt_q <= load_cnt_q + AW'(1);
    end
  end

  // distance to the centre tap, at least 1
  logic [DW-1:0] d_raw, tap_d;
  logic [15:0]   x16, diff;
  logic [16:0]   num;
  assign d_raw = (idx_q >= CENTRE_A) ? DW'(idx_q - CENTRE_A) : DW'(CENTRE_A - idx_q);
  assign tap_d = (d_raw == '0) ? DW'(1) : d_raw;
  assign x16   = {rdata_q, 8'd0};
  assign diff  = (x16 >= est_q) ? (x16 - est_q) : (est_q - x16);
  assign num   = {1'b0, diff} + 17'(tap_d >> 1);

  // shared divider
  logic              div_start, div_done;
  logic [SW+15:0]    div_num;
  logic [SW-1:0]     div_den;
  logic [15:0]       quot;
  logic [TW+7:0]     mean_num;

  assign mean_num  = {wt_q, 8'd0} + (TW+8)'(ws_q >> 1);
  assign div_start = cmd_i.dist_start || cmd_i.mean_start;
  assign div_num   = cmd_i.mean_start ? mean_num : (SW+16)'(num);
  assign div_den   = cmd_i.mean_start ? ws_q : SW'(tap_d);

  wmsf_div #(.VW(SW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // kernel interpolation
  logic [9:0]  kidx;
  logic [5:0]  kfrac;
  logic [24:0] klo, khi, w24;
  logic [30:0] kprod;
  logic [WW-1:0] wgt;
  assign kidx  = quot[15:6];
  assign kfrac = quot[5:0];
  assign klo   = wmsf_pkg::ktab(kidx[4:0]);
  assign khi   = wmsf_pkg::ktab(kidx[4:0] + 5'd1);
  assign kprod = 31'(klo - khi) * 31'(kfrac) + 31'd32;
  assign w24   = klo - 25'(kprod >> 6);
  assign wgt   = (kidx >= 10'(wmsf_pkg::KTAB_LEN)) ? '0 : WW'(w24 >> (24 - WEIGHT_BITS));

  // convergence test
  logic [15:0] change;
  logic [7:0]  lim_eff;
  logic        conv, at_limit;
  assign change   = (quot >= est_q) ? (quot - est_q) : (est_q - quot);
  assign conv     = (change < {8'd0, tol_i});
  assign lim_eff  = (limit_i == 8'd0) ? 8'd1 : limit_i;
  assign at_limit = (iter_q >= lim_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q  <= '0;
      ws_q   <= '0;
      wt_q   <= '0;
      iter_q <= '0;
      idx_q  <= '0;
      hit_q  <= 1'b0;
    end else begin
      if (cmd_i.init_est) begin
        est_q  <= {rdata_q, 8'd0};
        iter_q <= '0;
        hit_q  <= 1'b0;
      end
      if (cmd_i.iter_start) begin
        iter_q <= iter_q + 8'd1;
        ws_q   <= '0;
        wt_q   <= '0;
        idx_q  <= '0;
      end
      if (cmd_i.acc) begin
        ws_q  <= ws_q + SW'(w_q);
        wt_q  <= wt_q + TW'(w_q) * TW'(pix_q);
        idx_q <= (idx_q == LAST_A) ? '0 : idx_q + AW'(1);
      end
      if (cmd_i.update) begin
        est_q <= quot;
        hit_q <= !conv && at_limit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dist_start) pix_q <= rdata_q;
    if (cmd_i.kern)       w_q   <= wgt;
  end

  // output register
  logic [8:0] rnd;
  assign rnd = 9'(({1'b0, est_q} + 17'd128) >> 8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.emit) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      fv_q <= rnd[8] ? 8'd255 : rnd[7:0];
      lh_q <= hit_q;
      iu_q <= iter_q;
    end
  end

  assign st_o.div_done = div_done;
  assign st_o.last_idx = (idx_q == LAST_A);
  assign st_o.ws_zero  = (ws_q == '0);
  assign st_o.stop     = conv || at_limit;
  assign st_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign filtered_value_o  = fv_q;
  assign limit_hit_o       = lh_q;
  assign iterations_used_o = iu_q;

endmodule

// ----- rtl/window_meanshift_filter.sv -----
// ----------------------------------------------------------------------------
// window_meanshift_filter: Gaussian mean-shift smoothing of a pixel window
// Stores a (2R+1)^2 window, then refines the centre estimate iteratively.
// ----------------------------------------------------------------------------
// Flow: pixels are taken only while idle. After the last pixel the search
//   runs I iterations over the N = (2R+1)^2 pixels, then emits the result.
// Throughput: set by the one shared 16-step divider, used once per pixel
//   per iteration and once per iteration for the weighted mean.
// Reset: async active low; sequencer idle, counters and estimate cleared,
//   tolerance 3 and iteration limit 32. Window memory is not cleared.
module window_meanshift_filter #(
  parameter int unsigned RADIUS      = wmsf_pkg::RADIUS_DEF,
  parameter int unsigned WEIGHT_BITS = wmsf_pkg::WEIGHT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  wmsf_px_if.sink                        px_in,
  wmsf_res_if.source                     res_out,
  input  logic                           cfg_we_i,
  input  logic [wmsf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                     cfg_data_i
);

  // configuration registers
  logic [7:0] tol_q, limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= wmsf_pkg::TOL_RST;
      limit_q <= wmsf_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wmsf_pkg::CFG_TOLERANCE:  tol_q   <= cfg_data_i;
        wmsf_pkg::CFG_ITER_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wmsf_pkg::wmsf_cmd_t    cmd;
  wmsf_pkg::wmsf_status_t st;

  // sequencer: the input is taken only between searches
  wmsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (px_in.valid),
    .in_last_i  (px_in.last_pixel),
    .in_ready_o (px_in.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // datapath, with the result register facing the output channel
  wmsf_dp #(
    .RADIUS      (RADIUS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .st_o              (st),
    .pixel_i           (px_in.pixel),
    .last_i            (px_in.last_pixel),
    .tol_i             (tol_q),
    .limit_i           (limit_q),
    .out_ready_i       (res_out.ready),
    .out_valid_o       (res_out.valid),
    .filtered_value_o  (res_out.filtered_value),
    .limit_hit_o       (res_out.limit_hit),
    .iterations_used_o (res_out.iterations_used)
  );

endmodule
